/* design/bidalloc_pkg.sv */
`timescale 1ns / 1ps

package bidalloc_pkg;

    localparam int ID_W     = 6;
    localparam int POOL_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } st_t;

endpackage

/* design/bitmap_id_allocator_next_fit_core.sv */
`timescale 1ns / 1ps

// Next-fit ID allocator over POOLS pools of IDS IDs. A transaction is taken when start is high
// and busy is low; busy then stays high while the pool's bitmap and last-granted pointer are
// read from the state RAM, searched for the first clear bit at or after the pointer (wrapping
// to bit 0), and written back when an ID is granted or freed. The result appears on status and
// granted with done high for exactly one cycle, in the first cycle that busy is low, and a new
// transaction can be started in that cycle. The receiver cannot stall: sample the result
// whenever done is high. The RAM makes a single read-modify-write pass per transaction.
module bitmap_id_allocator_next_fit_core
    import bidalloc_pkg::*;
#(
    parameter int POOLS = 4,
    parameter int IDS   = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                kind,
    input  logic [POOL_W-1:0]   pool,
    input  logic [ID_W-1:0]     index,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     granted
);

    localparam int AW     = (POOLS > 1) ? $clog2(POOLS) : 1;
    localparam int PDEPTH = 2 ** AW;
    localparam int MEM_W  = IDS + ID_W;

    st_t st_reg;
    st_t st_next;

    logic                kind_reg;
    logic [POOL_W-1:0]   pool_reg;
    logic [ID_W-1:0]     index_reg;
    logic [PDEPTH-1:0]   valid_reg;
    logic [IDS-1:0]      map_reg;
    logic [ID_W-1:0]     ptr_reg;
    logic                hit_reg;
    logic [ID_W-1:0]     found_reg;
    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [ID_W-1:0]     granted_reg;

    logic                accept;
    logic                pool_ok;
    logic                index_ok;
    logic [MEM_W-1:0]    rdata;
    logic [IDS-1:0]      cur_map;
    logic [ID_W-1:0]     cur_ptr;
    logic                hit_hi;
    logic                hit_lo;
    logic [ID_W-1:0]     found_hi;
    logic [ID_W-1:0]     found_lo;
    logic                ram_re;
    logic                ram_we;
    logic [MEM_W-1:0]    ram_wdata;
    logic [IDS-1:0]      new_map;
    logic [ID_W-1:0]     new_ptr;
    logic                found_used;
    logic [STATUS_W-1:0] status_next;
    logic [ID_W-1:0]     granted_next;

    assign accept   = start && (st_reg == ST_IDLE);
    assign pool_ok  = ({1'b0, pool_reg} < 4'(POOLS));
    assign index_ok = ({1'b0, index_reg} < 7'(IDS));

    bidalloc_ram #(
        .WIDTH (MEM_W),
        .DEPTH (PDEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pool_reg[AW-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pool[AW-1:0]),
        .rdata (rdata)
    );

    // Entries never written read as free map, pointer zero
    always_comb
    begin
        if (valid_reg[pool_reg[AW-1:0]])
        begin
            cur_map = rdata[IDS-1:0];
            cur_ptr = rdata[MEM_W-1:IDS];
        end
        else
        begin
            cur_map = '0;
            cur_ptr = '0;
        end
    end

    always_comb
    begin
        hit_hi   = 1'b0;
        hit_lo   = 1'b0;
        found_hi = '0;
        found_lo = '0;
        for (int b = IDS - 1; b >= 0; b--)
        begin
            if (!cur_map[b])
            begin
                hit_lo   = 1'b1;
                found_lo = ID_W'(b);
                if (ID_W'(b) >= cur_ptr)
                begin
                    hit_hi   = 1'b1;
                    found_hi = ID_W'(b);
                end
            end
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    st_next = ST_READ;
                end
            end
            ST_READ:   st_next = ST_UPDATE;
            ST_UPDATE: st_next = ST_IDLE;
            default:   st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ram_re       = accept;
        new_map      = map_reg;
        new_ptr      = ptr_reg;
        ram_we       = 1'b0;
        status_next  = STATUS_OK;
        granted_next = '0;
        if (kind_reg == KIND_ALLOC)
        begin
            new_map = map_reg | (IDS'(1) << found_reg);
            new_ptr = found_reg;
        end
        else if (index_ok)
        begin
            new_map = map_reg & ~(IDS'(1) << index_reg);
        end
        if (!pool_ok)
        begin
            status_next = STATUS_INVALID;
        end
        else if (kind_reg == KIND_ALLOC)
        begin
            if (hit_reg)
            begin
                granted_next = found_reg;
            end
            else
            begin
                status_next = STATUS_FULL;
            end
        end
        if (st_reg == ST_UPDATE && pool_ok)
        begin
            ram_we = (kind_reg == KIND_ALLOC) ? hit_reg : index_ok;
        end
        ram_wdata = {new_ptr, new_map};
    end

    assign found_used = |(map_reg & (IDS'(1) << found_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= (st_reg == ST_UPDATE);
            if (ram_we)
            begin
                valid_reg[pool_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            pool_reg  <= pool;
            index_reg <= index;
        end
        if (st_reg == ST_READ)
        begin
            map_reg   <= cur_map;
            ptr_reg   <= cur_ptr;
            hit_reg   <= hit_hi || hit_lo;
            found_reg <= hit_hi ? found_hi : found_lo;
        end
        if (st_reg == ST_UPDATE)
        begin
            status_reg  <= status_next;
            granted_reg <= granted_next;
        end
    end

    assign busy    = (st_reg != ST_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign granted = granted_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(st_reg == ST_UPDATE))
        else $error("result strobe without a completed transaction");

    a_write_valid_pool: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (pool_ok && st_reg == ST_UPDATE))
        else $error("state write outside update or to an invalid pool");

    a_grant_was_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_UPDATE && kind_reg == KIND_ALLOC && hit_reg) |-> !found_used)
        else $error("granted an ID that is already in use");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transaction did not raise busy");

endmodule

/* design/bidalloc_ram.sv */
`timescale 1ns / 1ps

module bidalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
